/* rtl/cube_mip_chain_generator_assert.svh */
// Assertion macros for the cube mip chain generator.
`ifndef CUBE_MIP_CHAIN_GENERATOR_ASSERT_SVH
`define CUBE_MIP_CHAIN_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CMG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cube mip chain generator assertion failed");
`define CMG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cube mip chain generator assertion failed");
`else
`define CMG_ASSERT(lbl, prop)
`define CMG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/cmg_pkg.sv */
// Shared constants and types of the cube mip chain generator.
package cmg_pkg;

    localparam int MAX_SIZE_LOG2 = 8;
    localparam int CHANNEL_BITS  = 16;
    localparam int FACES         = 6;
    localparam int CHANNELS      = 4;

    localparam int MAX_SIZE  = 1 << MAX_SIZE_LOG2;
    localparam int LEVELS    = MAX_SIZE_LOG2;
    localparam int OUT_W     = 16;
    localparam int SUM_W     = 2 * MAX_SIZE_LOG2 + OUT_W;
    localparam int POS_W     = MAX_SIZE_LOG2;
    localparam int EDGE_W    = MAX_SIZE_LOG2 + 1;
    localparam int LOG_W     = 4;
    localparam int FACE_W    = 3;
    localparam int COORD_W   = 7;
    localparam int LEVEL_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_LOG2 = 1'b0,
        REG_LEVELS    = 1'b1
    } cfg_reg_t;

    typedef logic [OUT_W-1:0] chan_t;
    typedef chan_t [CHANNELS-1:0] texel_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef sum_t [CHANNELS-1:0] sum4_t;

    typedef struct packed {
        logic act;
        logic col_first;
        logic col_done;
        logic row_first;
        logic row_done;
    } lvl_ctl_t;

endpackage

/* rtl/cmg_if.sv */
// Stream interfaces: base texel words in, mip texel words out.
interface cmg_texel_if import cmg_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

interface cmg_mip_if import cmg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    chan_t              out_red;
    chan_t              out_green;
    chan_t              out_blue;
    chan_t              out_alpha;
    logic               last;

    modport source (output valid, output level, output face, output col, output row,
                    output out_red, output out_green, output out_blue, output out_alpha,
                    output last, input ready);
    modport sink   (input valid, input level, input face, input col, input row,
                    input out_red, input out_green, input out_blue, input out_alpha,
                    input last, output ready);
endinterface

/* rtl/cube_mip_chain_generator.sv */
// Top level of the cube mip chain generator: streaming 2x2 box filter over all levels.
//
// texel (sink) takes one base texel word per cycle while texel.ready is high, faces in order, rows then columns.
// mip (source) gives every finished lower-level texel word: level, face, col, row and
// the floored mean of each channel. The words caused by one texel leave in ascending
// level order, the final one with last set.
// cfg_we / cfg_index / cfg_data write size_log2 (index 0, restarts the position
// counters) or levels (index 1); write only while the block is idle.
// Throughput: one texel per cycle while texel.ready is high, set by the per-level column-sum
// memories, each read once at accept and written back once when stage 1 advances. A texel
// that finishes k levels holds the output burst register until its k words are taken; texels
// that finish nothing never wait on it. A texel's words reach mip through stage 1 and then the burst register.
// Reset initialises counters, config and valid state only; the sum stores need no clearing.
// When mip stalls, the burst register holds, the next emitting texel waits in stage 1
// and texel.ready drops until the burst can take it.
`include "cube_mip_chain_generator_assert.svh"

module cube_mip_chain_generator
    import cmg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cmg_texel_if.sink            texel,
    cmg_mip_if.source            mip,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // configuration and stream position
    logic [LOG_W-1:0]  size_log2_reg;
    logic [LOG_W-1:0]  levels_reg;
    logic [FACE_W-1:0] face_reg;
    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  col_reg;

    logic [LOG_W-1:0]  n_log;
    logic [LOG_W-1:0]  full;
    logic [LOG_W-1:0]  kept;
    logic [EDGE_W-1:0] s_edge;
    logic [EDGE_W-1:0] col_inc;
    logic [EDGE_W-1:0] row_inc;
    logic              accept;
    sum4_t             px;

    // stage 1: texel that has read its column sums
    logic              s1_valid_reg;
    logic [FACE_W-1:0] s1_face_reg;
    logic              s1_adv;
    logic [LEVELS-1:0] s1_emit;
    logic [LEVELS-1:0] collide;

    // output burst register: one slot per level
    logic [LEVELS-1:0]  bmask_reg;
    logic [LEVELS-1:0]  bmask_next;
    texel_t             bdata_reg [LEVELS];
    logic [COORD_W-1:0] bcol_reg  [LEVELS];
    logic [COORD_W-1:0] brow_reg  [LEVELS];
    logic [FACE_W-1:0]  bface_reg;
    logic [LEVELS-1:0]  blow;
    logic               bsingle;
    logic               bload;
    logic               bpop;

    texel_t             s1_res [LEVELS];
    logic [COORD_W-1:0] s1_col [LEVELS];
    logic [COORD_W-1:0] s1_row [LEVELS];

    assign n_log   = (size_log2_reg > LOG_W'(MAX_SIZE_LOG2)) ? LOG_W'(MAX_SIZE_LOG2)
                                                               : size_log2_reg;
    assign full    = n_log + LOG_W'(1);
    assign kept    = (levels_reg == '0 || levels_reg > full) ? full : levels_reg;
    assign s_edge  = EDGE_W'(1) << n_log;
    assign col_inc = {1'b0, col_reg} + EDGE_W'(1);
    assign row_inc = {1'b0, row_reg} + EDGE_W'(1);
    assign accept  = texel.valid && texel.ready;

    assign px[0] = SUM_W'(texel.red[CHANNEL_BITS-1:0]);
    assign px[1] = SUM_W'(texel.green[CHANNEL_BITS-1:0]);
    assign px[2] = SUM_W'(texel.blue[CHANNEL_BITS-1:0]);
    assign px[3] = SUM_W'(texel.alpha[CHANNEL_BITS-1:0]);

    // config writes and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= LOG_W'(MAX_SIZE_LOG2);
            levels_reg    <= '0;
            face_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SIZE_LOG2:
                begin
                    size_log2_reg <= cfg_data;
                    face_reg      <= '0;
                    row_reg       <= '0;
                    col_reg       <= '0;
                end
                REG_LEVELS: levels_reg <= cfg_data;
                default: ;
            endcase
        end
        else if (accept)
        begin
            if (col_inc >= s_edge)
            begin
                col_reg <= '0;
                if (row_inc >= s_edge)
                begin
                    row_reg  <= '0;
                    face_reg <= (face_reg == FACE_W'(FACES - 1)) ? '0 : face_reg + FACE_W'(1);
                end
                else
                begin
                    row_reg <= row_inc[POS_W-1:0];
                end
            end
            else
            begin
                col_reg <= col_inc[POS_W-1:0];
            end
        end
    end

    // per-level lanes: running row sum in flops, column sums in a memory bank
    for (genvar g = 0; g < LEVELS; g++)
    begin : g_lvl
        localparam int LV    = g + 1;
        localparam int AW    = (MAX_SIZE_LOG2 - LV > 0) ? MAX_SIZE_LOG2 - LV : 1;
        localparam int DEPTH = 1 << AW;
        localparam logic [POS_W-1:0] M = POS_W'((1 << LV) - 1);

        lvl_ctl_t          ctl;
        logic [AW-1:0]     seg;
        logic [AW-1:0]     ridx;
        sum4_t             ph_reg;
        sum4_t             ph_new;
        sum4_t             rd_reg;
        sum4_t             wsum;
        sum4_t             mem [DEPTH];
        lvl_ctl_t          s1_ctl_reg;
        logic [AW-1:0]     s1_seg_reg;
        logic [COORD_W-1:0] s1_col_reg;
        logic [COORD_W-1:0] s1_row_reg;
        sum4_t             s1_ph_reg;
        logic              wr_en;
        logic              rd_need;

        if (LV < MAX_SIZE_LOG2)
        begin : g_seg
            assign seg  = col_reg[POS_W-1:LV];
            assign ridx = row_reg[POS_W-1:LV];
        end
        else
        begin : g_one
            assign seg  = '0;
            assign ridx = '0;
        end

        assign ctl.act       = LOG_W'(LV) < kept;
        assign ctl.col_first = (col_reg & M) == '0;
        assign ctl.col_done  = (col_reg & M) == M;
        assign ctl.row_first = (row_reg & M) == '0;
        assign ctl.row_done  = (row_reg & M) == M;

        always_comb
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                ph_new[ch] = ctl.col_first ? px[ch] : ph_reg[ch] + px[ch];
                wsum[ch]   = s1_ctl_reg.row_first ? s1_ph_reg[ch]
                                                  : rd_reg[ch] + s1_ph_reg[ch];
                s1_res[g][ch] = OUT_W'(wsum[ch] >> (2 * LV));
            end
        end

        assign wr_en      = s1_adv && s1_ctl_reg.act && s1_ctl_reg.col_done;
        assign rd_need    = accept && ctl.act && ctl.col_done && !ctl.row_first;
        assign collide[g] = wr_en && rd_need && (s1_seg_reg == seg);
        assign s1_emit[g] = s1_valid_reg && s1_ctl_reg.act && s1_ctl_reg.col_done
                            && s1_ctl_reg.row_done;
        assign s1_col[g]  = s1_col_reg;
        assign s1_row[g]  = s1_row_reg;

        // hold the running row sum, capture stage 1 at accept
        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                if (ctl.act)
                begin
                    ph_reg <= ph_new;
                end
                s1_ctl_reg <= ctl;
                s1_seg_reg <= seg;
                s1_col_reg <= COORD_W'(seg);
                s1_row_reg <= COORD_W'(ridx);
                s1_ph_reg  <= ph_new;
            end
        end

        // column-sum bank: read at accept, write back when stage 1 advances
        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                rd_reg <= mem[seg];
            end
            if (wr_en)
            begin
                mem[s1_seg_reg] <= wsum;
            end
        end
    end

    assign bsingle = (bmask_reg != '0) && ((bmask_reg & (bmask_reg - LEVELS'(1))) == '0);
    assign blow    = bmask_reg & (~bmask_reg + LEVELS'(1));
    assign bpop    = mip.valid && mip.ready;
    assign s1_adv  = s1_valid_reg &&
                     (s1_emit == '0 || bmask_reg == '0 || (bsingle && mip.ready));
    assign bload   = s1_adv && (s1_emit != '0);
    assign texel.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        bmask_next = bmask_reg;
        if (bpop)
        begin
            bmask_next = bmask_reg & ~blow;
        end
        if (bload)
        begin
            bmask_next = s1_emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            bmask_reg    <= '0;
        end
        else
        begin
            bmask_reg <= bmask_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_face_reg <= face_reg;
        end
        if (bload)
        begin
            bface_reg <= s1_face_reg;
            for (int i = 0; i < LEVELS; i++)
            begin
                bdata_reg[i] <= s1_res[i];
                bcol_reg[i]  <= s1_col[i];
                brow_reg[i]  <= s1_row[i];
            end
        end
    end

    // deliver the lowest pending level
    always_comb
    begin
        mip.level     = '0;
        mip.col       = '0;
        mip.row       = '0;
        mip.out_red   = '0;
        mip.out_green = '0;
        mip.out_blue  = '0;
        mip.out_alpha = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (blow[i])
            begin
                mip.level     = mip.level | LEVEL_W'(i + 1);
                mip.col       = mip.col | bcol_reg[i];
                mip.row       = mip.row | brow_reg[i];
                mip.out_red   = mip.out_red | bdata_reg[i][0];
                mip.out_green = mip.out_green | bdata_reg[i][1];
                mip.out_blue  = mip.out_blue | bdata_reg[i][2];
                mip.out_alpha = mip.out_alpha | bdata_reg[i][3];
            end
        end
    end

    assign mip.valid = bmask_reg != '0;
    assign mip.face  = bface_reg;
    assign mip.last  = bsingle;

    // a column-sum write never lands on the entry the next texel reads
    `CMG_ASSERT(a_no_collide, collide == '0)
    // input stalls only behind an occupied stage 1
    `CMG_ASSERT(a_stall_cause, !texel.ready |-> s1_valid_reg)
    // a stalled burst keeps its pending levels
    `CMG_ASSERT_NEXT(a_burst_hold, mip.valid && !mip.ready, $stable(bmask_reg))

endmodule
